// ===== src/sms_pkg.sv =====
// Shared types and constants for the stable merge sorter.
// No dependencies; sms_cmp and stable_merge_sorter_core in src import this package.
package sms_pkg;

  // Capacity of the element store and width of one element.
  localparam int unsigned ITEM_CNT   = 64;
  localparam int unsigned VALUE_BITS = 32;

  // Address, count (holds ITEM_CNT itself) and span (holds lo + 2*width) widths.
  localparam int unsigned ADDR_W = $clog2(ITEM_CNT);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned SPAN_W = CNT_W + 1;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [SPAN_W-1:0]            span_t;

  // Input request: one element, last marks the end of the set.
  typedef struct packed {
    value_t value;
    logic   last;
  } in_req_t;

  // Output request: one sorted element with its flags.
  typedef struct packed {
    value_t sorted_value;
    logic   final_res;
    logic   overflow;
  } out_req_t;

endpackage

// ===== src/sms_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No package dependencies; used for the element store and the merge scratch.
module sms_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== src/sms_cmp.sv =====
// Shared signed compare unit used by every merge step.
// Depends on sms_pkg for the element type.
module sms_cmp (
  input  sms_pkg::value_t left_i,
  input  sms_pkg::value_t right_i,
  output logic            right_lt_o
);
  import sms_pkg::*;

  // True signed compare; ties report false so the left run wins and order stays stable.
  assign right_lt_o = (right_i < left_i);

endmodule

// ===== src/stable_merge_sorter_core.sv =====
// Top level of the stable merge sorter: sequencer, two ping-pong RAMs and the compare unit.
// Depends on sms_pkg, sms_ram and sms_cmp.
//
// The core loads signed elements one per cycle until a request marked last, keeping up to
// ITEM_CNT of them; later elements are dropped and every result of that set carries the
// overflow flag. It then runs a bottom-up stable merge sort, ping-ponging between two RAMs
// with one shared compare unit: each merge step has two states (RAM read, then compare and
// write), each run pair a setup state before them, and there are ceil(log2(n)) passes.
// Each result then goes through three steps (read, output load, handoff) and waits out any
// output stall. The input is stalled from the last request until the final result of the
// set has been taken.
module stable_merge_sorter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sms_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sms_pkg::out_req_t out_req_o
);
  import sms_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAIR,
    ST_RD,
    ST_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } state_e;

  state_e   state_q, state_d;
  cnt_t     count_q, count_d;
  logic     dropped_q, dropped_d;
  logic     src_q, src_d;
  cnt_t     width_q, width_d;
  cnt_t     lo_q, lo_d;
  cnt_t     mid_q, mid_d;
  cnt_t     hi_q, hi_d;
  cnt_t     i_q, i_d;
  cnt_t     j_q, j_d;
  cnt_t     k_q, k_d;
  logic     out_valid_q, out_valid_d;
  out_req_t out_req_q, out_req_d;

  logic     in_accept;
  logic     store_ok;
  cnt_t     n_load;
  span_t    mid_span, hi_span, width2;
  cnt_t     k_next;
  logic     take_left;
  logic     right_lt;
  value_t   left_val, right_val, merge_val;

  logic     mem0_we, mem1_we;
  addr_t    waddr, raddr_a, raddr_b;
  value_t   mem0_wdata;
  logic [VALUE_BITS-1:0] m0_rd_a, m0_rd_b, m1_rd_a, m1_rd_b;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign store_ok    = (count_q != cnt_t'(ITEM_CNT));
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // Run heads come from whichever RAM holds the current pass.
  assign left_val  = src_q ? value_t'(m1_rd_a) : value_t'(m0_rd_a);
  assign right_val = src_q ? value_t'(m1_rd_b) : value_t'(m0_rd_b);

  sms_cmp u_cmp (
    .left_i     (left_val),
    .right_i    (right_val),
    .right_lt_o (right_lt)
  );

  // Take the left head unless it is exhausted or the right head is strictly smaller.
  assign take_left = (i_q < mid_q) && ((j_q >= hi_q) || !right_lt);
  assign merge_val = take_left ? left_val : right_val;
  assign k_next    = k_q + cnt_t'(1);

  // Run boundaries for the next pair, clipped to the element count.
  assign mid_span = span_t'(lo_q) + span_t'(width_q);
  assign hi_span  = span_t'(lo_q) + (span_t'(width_q) << 1);
  assign width2   = span_t'(width_q) << 1;
  assign n_load   = store_ok ? count_q + cnt_t'(1) : count_q;

  // RAM port steering: loads land in RAM 0, merges write the RAM not being read.
  assign mem0_we    = (in_accept && store_ok) || (state_q == ST_WR && src_q);
  assign mem1_we    = (state_q == ST_WR) && !src_q;
  assign waddr      = (state_q == ST_LOAD) ? count_q[ADDR_W-1:0] : k_q[ADDR_W-1:0];
  assign mem0_wdata = (state_q == ST_LOAD) ? in_req_i.value : merge_val;
  assign raddr_a    = (state_q == ST_EMIT_RD) ? k_q[ADDR_W-1:0] : i_q[ADDR_W-1:0];
  assign raddr_b    = j_q[ADDR_W-1:0];

  sms_ram #(.DEPTH(ITEM_CNT), .WIDTH(VALUE_BITS)) u_store (
    .clk_i     (clk_i),
    .we_i      (mem0_we),
    .waddr_i   (waddr),
    .wdata_i   (mem0_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (m0_rd_a),
    .rdata_b_o (m0_rd_b)
  );

  sms_ram #(.DEPTH(ITEM_CNT), .WIDTH(VALUE_BITS)) u_scratch (
    .clk_i     (clk_i),
    .we_i      (mem1_we),
    .waddr_i   (waddr),
    .wdata_i   (merge_val),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (m1_rd_a),
    .rdata_b_o (m1_rd_b)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    src_d       = src_q;
    width_d     = width_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_req_d   = out_req_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_accept) begin
          count_d = n_load;
          if (!store_ok) begin
            dropped_d = 1'b1;
          end
          if (in_req_i.last) begin
            src_d   = 1'b0;
            k_d     = '0;
            lo_d    = '0;
            width_d = cnt_t'(1);
            state_d = (n_load == cnt_t'(1)) ? ST_EMIT_RD : ST_PAIR;
          end
        end
      end

      ST_PAIR: begin
        mid_d   = (mid_span < span_t'(count_q)) ? mid_span[CNT_W-1:0] : count_q;
        hi_d    = (hi_span < span_t'(count_q)) ? hi_span[CNT_W-1:0] : count_q;
        i_d     = lo_q;
        j_d     = (mid_span < span_t'(count_q)) ? mid_span[CNT_W-1:0] : count_q;
        k_d     = lo_q;
        state_d = ST_RD;
      end

      ST_RD: begin
        state_d = ST_WR;
      end

      ST_WR: begin
        k_d = k_next;
        if (take_left) begin
          i_d = i_q + cnt_t'(1);
        end else begin
          j_d = j_q + cnt_t'(1);
        end
        if (k_next == hi_q) begin
          if (hi_q == count_q) begin
            // Pass complete: swap RAM roles and double the run width.
            src_d = !src_q;
            lo_d  = '0;
            if (width2 >= span_t'(count_q)) begin
              k_d     = '0;
              state_d = ST_EMIT_RD;
            end else begin
              width_d = width2[CNT_W-1:0];
              state_d = ST_PAIR;
            end
          end else begin
            lo_d    = hi_q;
            state_d = ST_PAIR;
          end
        end else begin
          state_d = ST_RD;
        end
      end

      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        out_req_d.sorted_value = left_val;
        out_req_d.final_res    = (k_next == count_q);
        out_req_d.overflow     = dropped_q;
        out_valid_d            = 1'b1;
        state_d                = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          k_d         = k_next;
          if (k_next == count_q) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = ST_LOAD;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      src_q       <= 1'b0;
      width_q     <= '0;
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_req_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      src_q       <= src_d;
      width_q     <= width_d;
      lo_q        <= lo_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      out_req_q   <= out_req_d;
    end
  end

endmodule

// ===== dv/tb_stable_merge_sorter_core.sv =====
// Self-checking testbench for stable_merge_sorter_core: random sets of signed values,
// random idle and stall on both sides, results checked against a stable sort of each set.
// Depends on sms_pkg and the RTL in src.
module tb_stable_merge_sorter_core;
  import sms_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned DRAIN_TICKS = 40;
  localparam int unsigned TARGET_REQS = 260;

  localparam value_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam value_t VAL_MAX = ~VAL_MIN;

  typedef enum int unsigned {STYLE_WIDE, STYLE_CLUSTER, STYLE_CORNER} value_style_e;

  logic     clk_i     = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  in_req_t      pending_req_q[$];
  value_t       set_vals_q[$];
  bit           set_dropped;
  out_req_t     expected_sorted_q[$];
  out_req_t     sorted_head;

  int unsigned  in_gap;
  bit           in_burst;
  int unsigned  out_hold;
  int unsigned  out_draw;
  bit           out_burst;
  int unsigned  idle_cycles;
  int unsigned  error_cnt;
  int unsigned  reqs_queued;
  int unsigned  sets_closed;
  int unsigned  results_seen;
  int unsigned  overflow_seen;

  stable_merge_sorter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    error_cnt++;
  endtask

  // Wait before the next request, or length of the next output stall.
  function automatic int unsigned draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic value_t draw_value(value_style_e style);
    case (style)
      STYLE_WIDE:    return value_t'($urandom);
      STYLE_CLUSTER: return value_t'(int'($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 4))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return value_t'(0);
          3:       return value_t'(-1);
          default: return value_t'($urandom_range(0, 3));
        endcase
      end
    endcase
  endfunction

  task automatic add_request(value_t v, bit last);
    in_req_t req;
    req.value = v;
    req.last  = last;
    pending_req_q.push_back(req);
    reqs_queued++;
  endtask

  task automatic random_set(int unsigned n);
    value_style_e style;
    style = value_style_e'($urandom_range(0, 2));
    for (int unsigned i = 0; i < n; i++) begin
      add_request(draw_value(style), i == n - 1);
    end
  endtask

  // Takes one accepted request into the set; a request marked last closes the set and
  // queues its values in ascending stable order.
  task automatic absorb_request(in_req_t req);
    value_t   ordered_q[$];
    int       pos;
    out_req_t want;
    if (set_vals_q.size() < ITEM_CNT) begin
      set_vals_q.push_back(req.value);
    end else begin
      set_dropped = 1'b1;
    end
    if (req.last) begin
      // Insertion after every value that is not greater keeps equal values in arrival order.
      foreach (set_vals_q[i]) begin
        pos = ordered_q.size();
        while (pos > 0 && ordered_q[pos-1] > set_vals_q[i]) pos--;
        ordered_q.insert(pos, set_vals_q[i]);
      end
      foreach (ordered_q[k]) begin
        want.sorted_value = ordered_q[k];
        want.final_res    = (k == ordered_q.size() - 1);
        want.overflow     = set_dropped;
        expected_sorted_q.push_back(want);
      end
      set_vals_q.delete();
      set_dropped = 1'b0;
      sets_closed++;
    end
  endtask

  // Input driver: presents queued requests after a random gap and holds them while stalled.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= draw_wait(1'b0);
    end else if (!in_valid || !in_stall) begin
      if (in_gap == 0 && pending_req_q.size() > 0) begin
        in_req   <= pending_req_q.pop_front();
        in_valid <= 1'b1;
        in_gap   <= draw_wait(in_burst);
        if ($urandom_range(0, 19) == 0) in_burst <= !in_burst;
      end else begin
        in_valid <= 1'b0;
        if (in_gap != 0) in_gap <= in_gap - 1;
      end
    end
  end

  // Input monitor feeds every accepted request to the prediction.
  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_stall) absorb_request(in_req);
  end

  // Output stall: after each accepted result a random number of stall cycles follows.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && !out_stall) begin
      out_draw = draw_wait(out_burst);
      out_stall <= (out_draw != 0);
      out_hold  <= out_draw;
      if ($urandom_range(0, 19) == 0) out_burst <= !out_burst;
    end else if (out_hold != 0) begin
      out_hold  <= out_hold - 1;
      out_stall <= (out_hold > 1);
    end
  end

  // Output monitor compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sorted_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  out_req.sorted_value));
      end else begin
        sorted_head = expected_sorted_q.pop_front();
        if (out_req.sorted_value !== sorted_head.sorted_value)
          report_mismatch($sformatf("result %0d: sorted_value %0d, expected %0d", results_seen,
                                    out_req.sorted_value, sorted_head.sorted_value));
        if (out_req.final_res !== sorted_head.final_res)
          report_mismatch($sformatf("result %0d: final_res %b, expected %b", results_seen,
                                    out_req.final_res, sorted_head.final_res));
        if (out_req.overflow !== sorted_head.overflow)
          report_mismatch($sformatf("result %0d: overflow %b, expected %b", results_seen,
                                    out_req.overflow, sorted_head.overflow));
      end
      results_seen++;
      if (out_req.overflow) overflow_seen++;
    end
  end

  // Watchdog: ends the run when no request moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Timeout: no request accepted for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned set_idx;

    // Directed sets: a single element, the extremes with patterns that defeat a
    // subtracting compare, repeated values, and already ordered input both ways.
    add_request(value_t'(0), 1'b1);

    add_request(VAL_MAX, 1'b0);
    add_request(VAL_MIN, 1'b0);
    add_request(value_t'(0), 1'b0);
    add_request(value_t'(-1), 1'b0);
    add_request(value_t'(1), 1'b0);
    add_request(value_t'(32'hAAAA_AAAA), 1'b0);
    add_request(value_t'(32'h5555_5555), 1'b0);
    add_request(VAL_MIN, 1'b0);
    add_request(VAL_MAX, 1'b1);

    add_request(value_t'(3), 1'b0);
    add_request(value_t'(3), 1'b0);
    add_request(value_t'(-3), 1'b0);
    add_request(value_t'(3), 1'b0);
    add_request(value_t'(-3), 1'b1);

    add_request(value_t'(5), 1'b0);
    add_request(value_t'(-5), 1'b1);

    add_request(value_t'(1), 1'b0);
    add_request(value_t'(2), 1'b0);
    add_request(value_t'(3), 1'b0);
    add_request(value_t'(4), 1'b1);

    // Random sets, mostly small; one fills the store exactly and one overruns it,
    // including a dropped request marked last.
    set_idx = 0;
    while (reqs_queued < TARGET_REQS) begin
      if (set_idx == 5) random_set(ITEM_CNT);
      else if (set_idx == 12) random_set(ITEM_CNT + 3);
      else random_set($urandom_range(1, 10));
      set_idx++;
    end

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    // Drain: all requests in, all results out, then a short settling time.
    while (pending_req_q.size() != 0 || in_valid) @(negedge clk_i);
    while (expected_sorted_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_TICKS) @(negedge clk_i);
    if (expected_sorted_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_sorted_q.size()));

    $display("Covered %0d sets from %0d input requests under random idle and stall.",
             sets_closed, reqs_queued);
    $display("Checked %0d sorted results, %0d of them flagged as overflow; %0d mismatches.",
             results_seen, overflow_seen, error_cnt);
    if (error_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
